### hdl/vec3_arith_unit_defines.svh
// Assertion macros used by the vector arithmetic unit checker.
`ifndef VEC3_ARITH_UNIT_DEFINES_SVH
`define VEC3_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define VAU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define VAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/vau_pkg.sv
// Types and constants shared by the vector arithmetic unit modules.
`timescale 1ns / 1ps
package vau_pkg;

	localparam int WORD_W   = 32;
	localparam int PROD_W   = 64;
	localparam int SQ_STEPS = 32;
	localparam int Q_DEPTH  = 4;
	localparam int Q_PTR_W  = 2;
	localparam int Q_CNT_W  = 3;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_SCALE = 3'd3,
		CMD_CROSS = 3'd4,
		CMD_LEN   = 3'd5,
		CMD_NORM  = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		CLS_DIRECT,
		CLS_RESCALE,
		CLS_CROSS,
		CLS_LEN,
		CLS_NORM,
		CLS_ZERO
	} op_class_t;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PROD_W:0]   wide_t;

	typedef struct packed {
		op_class_t   cls;
		word_t [2:0] a;
		prod_t [5:0] p;
	} vau_item_t;

	typedef struct packed {
		logic      valid;
		vau_item_t item;
	} vau_push_t;

	typedef struct packed {
		op_class_t             cls;
		logic                  ov;
		word_t [2:0]           vec;
		logic [2:0][WORD_W-1:0] mag;
		logic [2:0]            neg;
	} vau_carry_t;

	function automatic prod_t sext_word(input word_t v);
		return {{(PROD_W-WORD_W){v[WORD_W-1]}}, v};
	endfunction

endpackage

### hdl/vau_front.sv
// Front end: accepts transactions, classifies the command and forms all products and sums.
`timescale 1ns / 1ps
module vau_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         cmd,
	input  vau_pkg::word_t     a_x,
	input  vau_pkg::word_t     a_y,
	input  vau_pkg::word_t     a_z,
	input  vau_pkg::word_t     b_x,
	input  vau_pkg::word_t     b_y,
	input  vau_pkg::word_t     b_z,
	input  vau_pkg::word_t     scale_factor,
	input  logic               q_full,
	output vau_pkg::vau_push_t push
);
	import vau_pkg::*;

	logic      valid_s1;
	vau_item_t item_s1;
	vau_item_t item_d;
	logic      load;
	word_t     op_a [6];
	word_t     op_b [6];
	prod_t     prod [6];
	prod_t     sums [3];
	word_t     av [3];
	word_t     bv [3];

	assign req_stall = valid_s1 && q_full;
	assign load      = req_valid && !req_stall;

	assign av[0] = a_x;
	assign av[1] = a_y;
	assign av[2] = a_z;
	assign bv[0] = b_x;
	assign bv[1] = b_y;
	assign bv[2] = b_z;

	always_comb begin
		item_d.cls = CLS_ZERO;
		for (int i = 0; i < 6; i++) begin
			op_a[i] = '0;
			op_b[i] = '0;
		end
		case (cmd_t'(cmd))
			CMD_ADD, CMD_SUB: begin
				item_d.cls = CLS_DIRECT;
			end
			CMD_MUL: begin
				item_d.cls = CLS_RESCALE;
				for (int i = 0; i < 3; i++) begin
					op_a[i] = av[i];
					op_b[i] = bv[i];
				end
			end
			CMD_SCALE: begin
				item_d.cls = CLS_RESCALE;
				for (int i = 0; i < 3; i++) begin
					op_a[i] = av[i];
					op_b[i] = scale_factor;
				end
			end
			CMD_CROSS: begin
				item_d.cls = CLS_CROSS;
				op_a[0] = a_y; op_b[0] = b_z;
				op_a[1] = a_z; op_b[1] = b_y;
				op_a[2] = a_z; op_b[2] = b_x;
				op_a[3] = a_x; op_b[3] = b_z;
				op_a[4] = a_x; op_b[4] = b_y;
				op_a[5] = a_y; op_b[5] = b_x;
			end
			CMD_LEN, CMD_NORM: begin
				item_d.cls = (cmd_t'(cmd) == CMD_LEN) ? CLS_LEN : CLS_NORM;
				for (int i = 0; i < 3; i++) begin
					op_a[i] = av[i];
					op_b[i] = av[i];
				end
			end
			default: begin
				item_d.cls = CLS_ZERO;
			end
		endcase
		for (int i = 0; i < 6; i++) begin
			prod[i] = sext_word(op_a[i]) * sext_word(op_b[i]);
		end
		for (int i = 0; i < 3; i++) begin
			if (cmd_t'(cmd) == CMD_SUB) begin
				sums[i] = sext_word(av[i]) - sext_word(bv[i]);
			end else begin
				sums[i] = sext_word(av[i]) + sext_word(bv[i]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			item_d.a[i] = av[i];
			item_d.p[i] = (item_d.cls == CLS_DIRECT) ? sums[i] : prod[i];
		end
		for (int i = 3; i < 6; i++) begin
			item_d.p[i] = prod[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_d;
		end
	end

	assign push.valid = valid_s1;
	assign push.item  = item_s1;

endmodule

### hdl/vau_queue.sv
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module vau_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  vau_pkg::vau_push_t push,
	output logic               full,
	input  logic               pop,
	output logic               nonempty,
	output vau_pkg::vau_item_t head
);
	import vau_pkg::*;

	vau_item_t          entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               wr;
	logic               rd;

	assign full     = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign wr       = push.valid && !full;
	assign rd       = pop && nonempty;
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= push.item;
		end
	end

endmodule

### hdl/vau_back.sv
// Back end: rescaling, saturation, pipelined square root and divider, result register.
`timescale 1ns / 1ps
module vau_back #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nonempty,
	input  vau_pkg::vau_item_t head,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output vau_pkg::word_t     res_x,
	output vau_pkg::word_t     res_y,
	output vau_pkg::word_t     res_z,
	output logic               overflow
);
	import vau_pkg::*;

	localparam int    SAT_BITS  = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
	localparam wide_t SAT_MAX   = (wide_t'(1) <<< (SAT_BITS - 1)) - wide_t'(1);
	localparam wide_t SAT_MIN   = -SAT_MAX - wide_t'(1);
	localparam wide_t RND       = (wide_t'(1) <<< FRAC_BITS) - wide_t'(1);
	localparam int    DIV_STEPS = FRAC_BITS + 1;
	localparam int    DIVW      = WORD_W + FRAC_BITS;
	localparam int    QW        = FRAC_BITS + 1;

	function automatic logic [WORD_W:0] sat_w(input wide_t v);
		if (v > SAT_MAX) begin
			return {1'b1, SAT_MAX[WORD_W-1:0]};
		end else if (v < SAT_MIN) begin
			return {1'b1, SAT_MIN[WORD_W-1:0]};
		end
		return {1'b0, v[WORD_W-1:0]};
	endfunction

	logic adv;

	logic        v_s1;
	op_class_t   cls_s1;
	word_t       a_s1 [3];
	wide_t       d_s1 [3];
	logic [63:0] ssq_s1;
	wide_t       d_d [3];
	logic [63:0] ssq_d;
	vau_carry_t  c2_d;

	logic        sq_v_s    [SQ_STEPS+1];
	vau_carry_t  sq_c_s    [SQ_STEPS+1];
	logic [63:0] sq_rem_s  [SQ_STEPS+1];
	logic [63:0] sq_root_s [SQ_STEPS+1];
	logic [63:0] sq_nrem   [SQ_STEPS];
	logic [63:0] sq_nroot  [SQ_STEPS];

	logic              dv_v_s   [DIV_STEPS+1];
	vau_carry_t        dv_c_s   [DIV_STEPS+1];
	logic [WORD_W-1:0] dv_len_s [DIV_STEPS+1];
	logic [DIVW-1:0]   dv_rem_s [DIV_STEPS+1][3];
	logic [QW-1:0]     dv_q_s   [DIV_STEPS+1][3];
	logic [DIVW-1:0]   dv_nrem  [DIV_STEPS][3];
	logic [QW-1:0]     dv_nq    [DIV_STEPS][3];

	word_t res_d [3];
	logic  ov_d;
	logic  rsp_valid_q;
	word_t res_x_q;
	word_t res_y_q;
	word_t res_z_q;
	logic  overflow_q;

	assign adv = !rsp_valid_q || !rsp_stall;
	assign pop = adv && q_nonempty;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (head.cls == CLS_CROSS) begin
				d_d[i] = wide_t'($signed(head.p[2*i])) - wide_t'($signed(head.p[2*i+1]));
			end else begin
				d_d[i] = wide_t'($signed(head.p[i]));
			end
		end
		ssq_d = head.p[0] + head.p[1] + head.p[2];
	end

	always_comb begin
		logic [WORD_W:0]   sw;
		wide_t             rs;
		logic [WORD_W-1:0] ua;
		c2_d.cls = cls_s1;
		c2_d.ov  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (d_s1[i] < 0) begin
				rs = (d_s1[i] + RND) >>> FRAC_BITS;
			end else begin
				rs = d_s1[i] >>> FRAC_BITS;
			end
			sw = sat_w((cls_s1 == CLS_DIRECT) ? d_s1[i] : rs);
			ua = a_s1[i];
			c2_d.neg[i] = a_s1[i][WORD_W-1];
			c2_d.mag[i] = c2_d.neg[i] ? (WORD_W'(0) - ua) : ua;
			case (cls_s1)
				CLS_DIRECT, CLS_RESCALE, CLS_CROSS: begin
					c2_d.vec[i] = sw[WORD_W-1:0];
					c2_d.ov     = c2_d.ov | sw[WORD_W];
				end
				CLS_NORM: begin
					c2_d.vec[i] = a_s1[i];
				end
				default: begin
					c2_d.vec[i] = '0;
				end
			endcase
		end
	end

	always_comb begin
		logic [63:0] bitv;
		logic [63:0] trial;
		for (int k = 0; k < SQ_STEPS; k++) begin
			bitv  = 64'd1 << (62 - 2 * k);
			trial = sq_root_s[k] + bitv;
			if (sq_rem_s[k] >= trial) begin
				sq_nrem[k]  = sq_rem_s[k] - trial;
				sq_nroot[k] = (sq_root_s[k] >> 1) + bitv;
			end else begin
				sq_nrem[k]  = sq_rem_s[k];
				sq_nroot[k] = sq_root_s[k] >> 1;
			end
		end
	end

	always_comb begin
		logic [DIVW-1:0] sh;
		logic            ge;
		for (int j = 0; j < DIV_STEPS; j++) begin
			sh = DIVW'(dv_len_s[j]) << (FRAC_BITS - j);
			for (int i = 0; i < 3; i++) begin
				ge            = dv_rem_s[j][i] >= sh;
				dv_nrem[j][i] = ge ? (dv_rem_s[j][i] - sh) : dv_rem_s[j][i];
				dv_nq[j][i]   = dv_q_s[j][i] | (ge ? (QW'(1) << (FRAC_BITS - j)) : QW'(0));
			end
		end
	end

	always_comb begin
		logic [WORD_W:0]   sw;
		wide_t             val;
		vau_carry_t        fin;
		logic [WORD_W-1:0] len_f;
		fin   = dv_c_s[DIV_STEPS];
		len_f = dv_len_s[DIV_STEPS];
		ov_d  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			res_d[i] = '0;
		end
		case (fin.cls)
			CLS_LEN: begin
				sw       = sat_w(wide_t'({1'b0, len_f}));
				res_d[0] = sw[WORD_W-1:0];
				ov_d     = sw[WORD_W];
			end
			CLS_NORM: begin
				for (int i = 0; i < 3; i++) begin
					if (len_f == '0) begin
						val = wide_t'($signed(fin.vec[i]));
					end else if (fin.neg[i]) begin
						val = -wide_t'({1'b0, dv_q_s[DIV_STEPS][i]});
					end else begin
						val = wide_t'({1'b0, dv_q_s[DIV_STEPS][i]});
					end
					sw       = sat_w(val);
					res_d[i] = sw[WORD_W-1:0];
					ov_d     = ov_d | sw[WORD_W];
				end
			end
			default: begin
				for (int i = 0; i < 3; i++) begin
					res_d[i] = fin.vec[i];
				end
				ov_d = fin.ov;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= SQ_STEPS; k++) begin
				sq_v_s[k] <= 1'b0;
			end
			for (int j = 0; j <= DIV_STEPS; j++) begin
				dv_v_s[j] <= 1'b0;
			end
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= q_nonempty;
			sq_v_s[0] <= v_s1;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
			dv_v_s[0] <= sq_v_s[SQ_STEPS];
			for (int j = 0; j < DIV_STEPS; j++) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
			rsp_valid_q <= dv_v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1 <= head.cls;
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= head.a[i];
				d_s1[i] <= d_d[i];
			end
			ssq_s1 <= ssq_d;

			sq_c_s[0]    <= c2_d;
			sq_rem_s[0]  <= ssq_s1;
			sq_root_s[0] <= '0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_c_s[k+1]    <= sq_c_s[k];
				sq_rem_s[k+1]  <= sq_nrem[k];
				sq_root_s[k+1] <= sq_nroot[k];
			end

			dv_c_s[0]   <= sq_c_s[SQ_STEPS];
			dv_len_s[0] <= sq_root_s[SQ_STEPS][WORD_W-1:0];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= DIVW'(sq_c_s[SQ_STEPS].mag[i]) << FRAC_BITS;
				dv_q_s[0][i]   <= '0;
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				dv_c_s[j+1]   <= dv_c_s[j];
				dv_len_s[j+1] <= dv_len_s[j];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[j+1][i] <= dv_nrem[j][i];
					dv_q_s[j+1][i]   <= dv_nq[j][i];
				end
			end

			res_x_q    <= res_d[0];
			res_y_q    <= res_d[1];
			res_z_q    <= res_d[2];
			overflow_q <= ov_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign res_x     = res_x_q;
	assign res_y     = res_y_q;
	assign res_z     = res_z_q;
	assign overflow  = overflow_q;

endmodule

### hdl/vec3_arith_unit.sv
// Top level of the three-component fixed-point vector arithmetic unit.
// Usage:
// The request channel (req_valid, req_stall) carries one transaction per command:
// an opcode, two vectors a and b and a scalar, all signed fixed point.
// The response channel (rsp_valid, rsp_stall) returns one transaction per
// request, in request order: res_x, res_y, res_z and the overflow flag.
// Throughput is one transaction per cycle while rsp_stall stays low; the depth
// comes from the one-bit-per-stage square root (32 stages) and the restoring
// divider (FRAC_BITS + 1 stages) that every transaction flows through.
// A four-entry queue sits between the front end and the back end.
// While rsp_stall is high with a response pending, the back end holds, the result
// register holds, the queue fills, and req_stall rises once the queue is full.
// Reset (arst_n low) empties the pipeline and the queue; no response is
// pending after reset and both channels are ready at once.
`timescale 1ns / 1ps
module vec3_arith_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  logic [2:0]     cmd,
	input  vau_pkg::word_t a_x,
	input  vau_pkg::word_t a_y,
	input  vau_pkg::word_t a_z,
	input  vau_pkg::word_t b_x,
	input  vau_pkg::word_t b_y,
	input  vau_pkg::word_t b_z,
	input  vau_pkg::word_t scale_factor,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vau_pkg::word_t res_x,
	output vau_pkg::word_t res_y,
	output vau_pkg::word_t res_z,
	output logic           overflow
);
	import vau_pkg::*;

	vau_push_t push;
	logic      q_full;
	logic      q_nonempty;
	logic      pop;
	vau_item_t head;

	vau_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.a_x          (a_x),
		.a_y          (a_y),
		.a_z          (a_z),
		.b_x          (b_x),
		.b_y          (b_y),
		.b_z          (b_z),
		.scale_factor (scale_factor),
		.q_full       (q_full),
		.push         (push)
	);

	vau_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.head     (head)
	);

	vau_back #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.res_x      (res_x),
		.res_y      (res_y),
		.res_z      (res_z),
		.overflow   (overflow)
	);

endmodule

### hdl/vau_checker.sv
// Port-level checker for the vector arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`include "vec3_arith_unit_defines.svh"
module vau_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [31:0] res_x,
	input logic signed [31:0] res_y,
	input logic signed [31:0] res_z,
	input logic               overflow
);
	localparam int                 SAT_BITS  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam logic signed [63:0] SAT_MAX64 = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
	localparam logic signed [31:0] SAT_HI    = SAT_MAX64[31:0];
	localparam logic signed [31:0] SAT_LO    = ~SAT_HI;

	`VAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(res_x) && $stable(res_y) && $stable(res_z) && $stable(overflow), "Stalled response transaction changed or vanished.")

	`VAU_ASSERT_IMPL(a_ovf_bound, rsp_valid && overflow, res_x == SAT_HI || res_x == SAT_LO || res_y == SAT_HI || res_y == SAT_LO || res_z == SAT_HI || res_z == SAT_LO, "Overflow flagged with no component at a saturation bound.")

	`VAU_ASSERT_IMPL(a_stall_cause, $rose(req_stall), $past(req_valid && !req_stall), "Request stall rose without a preceding accepted transaction.")

endmodule

bind vec3_arith_unit vau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_vau_checker (.*);

### sim/tb_vec3_arith_unit.sv
// Self-checking testbench for the fixed-point vector arithmetic unit.
`timescale 1ns / 1ps
module tb_vec3_arith_unit;
	import vau_pkg::*;

	localparam int FRAC = 16;
	localparam logic [2:0] CMD_RSVD = 3'd7;
	localparam int N_RANDOM = 550;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [2:0] op;
		word_t ax, ay, az, bx, by, bz, sf;
	} vec_req_t;

	typedef struct {
		word_t rx, ry, rz;
		logic ov;
	} vec_rsp_t;

	typedef logic signed [129:0] big_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [2:0] cmd = 3'd0;
	word_t a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
	word_t scale_factor = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	word_t res_x, res_y, res_z;
	logic overflow;

	vec_req_t pending_reqs[$];
	vec_rsp_t expected_rsps[$];
	int n_req_taken = 0;
	int n_req_driven = 0;
	int n_rsp_taken = 0;
	int n_rsp_seen = 0;
	int req_gap = 0;
	int rsp_hold = 0;
	int errors = 0;
	bit stim_done = 1'b0;

	vec3_arith_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .cmd(cmd),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.scale_factor(scale_factor),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.res_x(res_x), .res_y(res_y), .res_z(res_z), .overflow(overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic word_t clamp_word(input big_t v, inout logic ov);
		if (v > big_t'(32'sh7fffffff)) begin
			ov = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -big_t'(33'sh080000000)) begin
			ov = 1'b1;
			return 32'sh80000000;
		end
		return word_t'(v[31:0]);
	endfunction

	function automatic big_t drop_frac(input big_t p);
		big_t m;
		if (p < 0) begin
			m = -p;
			return -(m >> FRAC);
		end
		return p >> FRAC;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] root, bit_v;
		root = '0;
		bit_v = 64'h1 << 62;
		while (bit_v > n)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (n >= root + bit_v) begin
				n = n - (root + bit_v);
				root = (root >> 1) + bit_v;
			end else begin
				root = root >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return root;
	endfunction

	function automatic vec_rsp_t vec_predict(input vec_req_t q);
		big_t a[3], b[3], s, r[3], len;
		logic [63:0] sumsq;
		vec_rsp_t o;
		logic ov;
		ov = 1'b0;
		a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
		b[0] = q.bx; b[1] = q.by; b[2] = q.bz;
		s = q.sf;
		foreach (r[i]) r[i] = 0;
		sumsq = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
		len = big_t'({1'b0, int_sqrt(sumsq)});
		case (q.op)
			CMD_ADD: foreach (r[i]) r[i] = a[i] + b[i];
			CMD_SUB: foreach (r[i]) r[i] = a[i] - b[i];
			CMD_MUL: foreach (r[i]) r[i] = drop_frac(a[i] * b[i]);
			CMD_SCALE: foreach (r[i]) r[i] = drop_frac(a[i] * s);
			CMD_CROSS: begin
				r[0] = drop_frac(a[1] * b[2] - a[2] * b[1]);
				r[1] = drop_frac(a[2] * b[0] - a[0] * b[2]);
				r[2] = drop_frac(a[0] * b[1] - a[1] * b[0]);
			end
			CMD_LEN: r[0] = len;
			CMD_NORM: begin
				if (len == 0)
					foreach (r[i]) r[i] = a[i];
				else
					foreach (r[i]) r[i] = (a[i] <<< FRAC) / len;
			end
			default: ;
		endcase
		o.rx = clamp_word(r[0], ov);
		o.ry = clamp_word(r[1], ov);
		o.rz = clamp_word(r[2], ov);
		o.ov = ov;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
		errors++;
	endtask

	function automatic word_t rand_word(input int style);
		case (style)
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			2: return word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sh0;
					3: return 32'sh00010000;
					default: return -32'sh00010000;
				endcase
			end
		endcase
	endfunction

	task automatic queue_req(input logic [2:0] op, input word_t ax, ay, az, bx, by, bz, sf);
		vec_req_t q;
		q.op = op; q.ax = ax; q.ay = ay; q.az = az;
		q.bx = bx; q.by = by; q.bz = bz; q.sf = sf;
		pending_reqs.push_back(q);
	endtask

	// Driver: holds a transaction until it is taken, then idles for a drawn gap.
	always @(negedge clk) begin
		vec_req_t q;
		if (arst_n) begin
			if (n_req_driven != n_req_taken) begin
				req_valid <= 1'b1;
			end else if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				q = pending_reqs.pop_front();
				cmd <= q.op;
				a_x <= q.ax; a_y <= q.ay; a_z <= q.az;
				b_x <= q.bx; b_y <= q.by; b_z <= q.bz;
				scale_factor <= q.sf;
				req_valid <= 1'b1;
				n_req_driven++;
				req_gap = ((n_req_driven / 64) % 3 == 1) ? 0 : $urandom_range(0, 10);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response side back-pressure, redrawn after every accepted transaction.
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_rsp_seen != n_rsp_taken) begin
				n_rsp_seen = n_rsp_taken;
				rsp_hold = ((n_rsp_taken / 64) % 3 == 2) ? 0 : $urandom_range(0, 10);
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		vec_req_t q;
		vec_rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				q.op = cmd; q.ax = a_x; q.ay = a_y; q.az = a_z;
				q.bx = b_x; q.by = b_y; q.bz = b_z; q.sf = scale_factor;
				expected_rsps.push_back(vec_predict(q));
				n_req_taken++;
			end
			if (rsp_valid && !rsp_stall) begin
				n_rsp_taken++;
				if (expected_rsps.size() == 0) begin
					$display("MISMATCH unexpected transaction at %0t", $realtime);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (res_x !== want.rx) report_mismatch("res_x", res_x, want.rx);
					if (res_y !== want.ry) report_mismatch("res_y", res_y, want.ry);
					if (res_z !== want.rz) report_mismatch("res_z", res_z, want.rz);
					if (overflow !== want.ov)
						report_mismatch("overflow", 32'(overflow), 32'(want.ov));
				end
			end
		end
	end

	initial begin
		int style;
		word_t mx, mn, one;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		one = 32'sh00010000;
		queue_req(CMD_ADD, mx, mn, one, one, mn, -one, 0);
		queue_req(CMD_SUB, mn, mx, 5, one, mn, 7, 0);
		queue_req(CMD_MUL, mn, mx, -3 * one, mn, mx, 2 * one, 0);
		queue_req(CMD_MUL, -one, 3, one / 2, -7, one, one / 2, 0);
		queue_req(CMD_SCALE, mx, mn, -5 * one, 0, 0, 0, mn);
		queue_req(CMD_SCALE, one, -one, 12345, 0, 0, 0, one / 4);
		queue_req(CMD_CROSS, mn, mn, mx, mx, mn, mn, 0);
		queue_req(CMD_CROSS, one, 0, 0, 0, one, 0, 0);
		queue_req(CMD_LEN, mn, mn, mn, 0, 0, 0, 0);
		queue_req(CMD_LEN, 3 * one, 4 * one, 0, 0, 0, 0, 0);
		queue_req(CMD_LEN, 0, 0, 0, 0, 0, 0, 0);
		queue_req(CMD_LEN, 1, 0, 0, 0, 0, 0, 0);
		queue_req(CMD_NORM, 0, 0, 0, mx, mx, mx, mx);
		queue_req(CMD_NORM, -one, 0, 0, 0, 0, 0, 0);
		queue_req(CMD_NORM, 3 * one, -4 * one, 0, 0, 0, 0, 0);
		queue_req(CMD_NORM, mn, mx, mn, 0, 0, 0, 0);
		queue_req(CMD_NORM, 1, -1, 1, 0, 0, 0, 0);
		queue_req(CMD_RSVD, mx, mn, one, mx, mn, one, mx);
		queue_req(CMD_RSVD, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < N_RANDOM; i++) begin
			style = $urandom_range(0, 3);
			queue_req(3'($urandom_range(0, 7)), rand_word(style), rand_word(style),
				rand_word(style), rand_word(style), rand_word(style), rand_word(style),
				rand_word($urandom_range(0, 3)));
		end
		stim_done = 1'b1;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done);
		wait (pending_reqs.size() == 0 && n_req_driven == n_req_taken
			&& expected_rsps.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_rsps.size() != 0) begin
			$display("MISMATCH %0d transactions never returned", expected_rsps.size());
			errors++;
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/vau_pkg.sv
hdl/vau_front.sv
hdl/vau_queue.sv
hdl/vau_back.sv
hdl/vec3_arith_unit.sv
hdl/vau_checker.sv
sim/tb_vec3_arith_unit.sv
